/* src/stok_pkg.sv */
// Shared types, token codes, character codes and keyword tables of the source tokenizer.
// Used by the front, queue, back and checker modules; depends on nothing.
package stok_pkg;

    // Token kinds
    localparam logic [4:0] TK_EOF    = 5'd0;
    localparam logic [4:0] TK_PLUS   = 5'd1;
    localparam logic [4:0] TK_MINUS  = 5'd2;
    localparam logic [4:0] TK_STAR   = 5'd3;
    localparam logic [4:0] TK_SLASH  = 5'd4;
    localparam logic [4:0] TK_AND    = 5'd5;
    localparam logic [4:0] TK_OR     = 5'd6;
    localparam logic [4:0] TK_EQUAL  = 5'd7;
    localparam logic [4:0] TK_EQEQ   = 5'd8;
    localparam logic [4:0] TK_NE     = 5'd9;
    localparam logic [4:0] TK_GT     = 5'd10;
    localparam logic [4:0] TK_LT     = 5'd11;
    localparam logic [4:0] TK_SEMI   = 5'd12;
    localparam logic [4:0] TK_LPAREN = 5'd13;
    localparam logic [4:0] TK_RPAREN = 5'd14;
    localparam logic [4:0] TK_LBRACE = 5'd15;
    localparam logic [4:0] TK_RBRACE = 5'd16;
    localparam logic [4:0] TK_NUMBER = 5'd17;
    localparam logic [4:0] TK_KW0    = 5'd18;
    localparam logic [4:0] TK_IDENT  = 5'd24;
    localparam logic [4:0] TK_ERROR  = 5'd25;

    // Character codes
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LZ     = 8'h7A;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5A;

    localparam logic [15:0] LEN_MAX  = 16'hFFFF;
    localparam int          NUM_KW   = 6;
    localparam logic [5:0]  ALL_KW   = 6'h3F;

    // Keyword spelling: print, if, while, else, input, let
    localparam logic [7:0] KW_TEXT [NUM_KW][5] = '{
        '{"p", "r", "i", "n", "t"},
        '{"i", "f", 8'h00, 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e"},
        '{"e", "l", "s", "e", 8'h00},
        '{"i", "n", "p", "u", "t"},
        '{"l", "e", "t", 8'h00, 8'h00}
    };
    localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd5, 3'd2, 3'd5, 3'd4, 3'd5, 3'd3};

    typedef struct packed {
        logic [4:0]  kind;
        logic [23:0] start;
        logic [15:0] length;
        logic [7:0]  bad;
    } result_t;

    // One queue entry: the tokens caused by one item
    typedef struct packed {
        result_t r0;
        result_t r1;
        logic    two;
    } record_t;

    // Drop keyword candidates that do not match byte c at index idx
    function automatic logic [5:0] narrow_mask(logic [5:0] mask, logic [15:0] idx,
                                               logic [7:0] c);
        logic [5:0] res;
        res = mask;
        for (int k = 0; k < NUM_KW; k++) begin
            if (mask[k])
            begin
                if (idx >= 16'(KW_LEN[k]))
                begin
                    res[k] = 1'b0;
                end
                else if (KW_TEXT[k][idx[2:0]] != c)
                begin
                    res[k] = 1'b0;
                end
            end
        end
        return res;
    endfunction

    // First surviving candidate of matching length, else identifier
    function automatic logic [4:0] ident_kind(logic [5:0] mask, logic [15:0] len);
        logic [4:0] res;
        res = TK_IDENT;
        for (int k = NUM_KW - 1; k >= 0; k--) begin
            if (mask[k] && len == 16'(KW_LEN[k]))
            begin
                res = TK_KW0 + 5'(k);
            end
        end
        return res;
    endfunction

endpackage

/* src/stok_front.sv */
// Front end of the source tokenizer: accepts bytes, tracks scan state, builds token records.
// Depends on stok_pkg.
module stok_front #(
    parameter int POSITION_BITS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic               kind,
    input  logic [7:0]         char_byte,
    output logic               push,
    output stok_pkg::record_t  rec
);

    typedef enum logic [3:0] {
        M_IDLE, M_SLASH, M_COMMENT, M_AMP, M_PIPE, M_EQ, M_BANG, M_NUMBER, M_IDENT
    } mode_t;

    mode_t                    mode_reg, mode_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] begin_reg, begin_next;
    logic [15:0]              run_reg, run_next;
    logic [5:0]               mask_reg, mask_next;
    logic                     err_reg, err_next;

    stok_pkg::result_t fl_res, st_res, res_a, res_b;
    logic              fl_emit, fl_err;
    logic              st_emit, st_err, st_word, st_ident;
    mode_t             st_mode;
    logic [4:0]        st_single;
    logic              is_digit, is_alnum;
    logic              fa, fb, do_flush, do_start;
    logic [15:0]       run_grow;

    assign is_digit = char_byte inside {[stok_pkg::CH_0:stok_pkg::CH_9]};
    assign is_alnum = is_digit
                   || (char_byte inside {[stok_pkg::CH_LA:stok_pkg::CH_LZ]})
                   || (char_byte inside {[stok_pkg::CH_UA:stok_pkg::CH_UZ]});
    assign run_grow = (run_reg == stok_pkg::LEN_MAX) ? run_reg : run_reg + 16'd1;

    // Decode the token that a pending mode yields when it ends
    always_comb
    begin
        fl_res  = '0;
        fl_emit = 1'b0;
        fl_err  = 1'b0;
        fl_res.start  = 24'(begin_reg);
        fl_res.length = 16'd1;
        case (mode_reg)
            M_SLASH:
            begin
                fl_emit = 1'b1;
                fl_res.kind = stok_pkg::TK_SLASH;
            end
            M_EQ:
            begin
                fl_emit = 1'b1;
                fl_res.kind = stok_pkg::TK_EQUAL;
            end
            M_NUMBER:
            begin
                fl_emit = 1'b1;
                fl_res.kind   = stok_pkg::TK_NUMBER;
                fl_res.length = run_reg;
            end
            M_IDENT:
            begin
                fl_emit = 1'b1;
                fl_res.kind   = stok_pkg::ident_kind(mask_reg, run_reg);
                fl_res.length = run_reg;
            end
            M_AMP:
            begin
                fl_emit = 1'b1;
                fl_err  = 1'b1;
                fl_res.kind = stok_pkg::TK_ERROR;
                fl_res.bad  = stok_pkg::CH_AMP;
            end
            M_PIPE:
            begin
                fl_emit = 1'b1;
                fl_err  = 1'b1;
                fl_res.kind = stok_pkg::TK_ERROR;
                fl_res.bad  = stok_pkg::CH_PIPE;
            end
            M_BANG:
            begin
                fl_emit = 1'b1;
                fl_err  = 1'b1;
                fl_res.kind = stok_pkg::TK_ERROR;
                fl_res.bad  = stok_pkg::CH_BANG;
            end
            default:
            begin
                fl_emit = 1'b0;
            end
        endcase
    end

    // Classify the byte as the first byte of a new token
    always_comb
    begin
        st_mode   = M_IDLE;
        st_single = stok_pkg::TK_EOF;
        st_err    = 1'b0;
        st_word   = 1'b0;
        st_ident  = 1'b0;
        case (char_byte)
            stok_pkg::CH_SPACE, stok_pkg::CH_TAB,
            stok_pkg::CH_CR, stok_pkg::CH_LF: st_mode = M_IDLE;
            stok_pkg::CH_PLUS:   st_single = stok_pkg::TK_PLUS;
            stok_pkg::CH_MINUS:  st_single = stok_pkg::TK_MINUS;
            stok_pkg::CH_STAR:   st_single = stok_pkg::TK_STAR;
            stok_pkg::CH_GT:     st_single = stok_pkg::TK_GT;
            stok_pkg::CH_LT:     st_single = stok_pkg::TK_LT;
            stok_pkg::CH_SEMI:   st_single = stok_pkg::TK_SEMI;
            stok_pkg::CH_LPAREN: st_single = stok_pkg::TK_LPAREN;
            stok_pkg::CH_RPAREN: st_single = stok_pkg::TK_RPAREN;
            stok_pkg::CH_LBRACE: st_single = stok_pkg::TK_LBRACE;
            stok_pkg::CH_RBRACE: st_single = stok_pkg::TK_RBRACE;
            stok_pkg::CH_SLASH:  st_mode = M_SLASH;
            stok_pkg::CH_AMP:    st_mode = M_AMP;
            stok_pkg::CH_PIPE:   st_mode = M_PIPE;
            stok_pkg::CH_EQ:     st_mode = M_EQ;
            stok_pkg::CH_BANG:   st_mode = M_BANG;
            default:
            begin
                if (is_digit)
                begin
                    st_mode = M_NUMBER;
                    st_word = 1'b1;
                end
                else if (is_alnum)
                begin
                    st_mode  = M_IDENT;
                    st_word  = 1'b1;
                    st_ident = 1'b1;
                end
                else
                begin
                    st_err = 1'b1;
                end
            end
        endcase
        st_emit = st_err || (st_single != stok_pkg::TK_EOF);
        st_res.kind   = st_err ? stok_pkg::TK_ERROR : st_single;
        st_res.start  = 24'(pos_reg);
        st_res.length = 16'd1;
        st_res.bad    = st_err ? char_byte : 8'h00;
    end

    // Advance the scan state and collect up to two tokens
    always_comb
    begin
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        begin_next = begin_reg;
        run_next   = run_reg;
        mask_next  = mask_reg;
        err_next   = err_reg;
        fa         = 1'b0;
        fb         = 1'b0;
        res_a      = fl_res;
        res_b      = st_res;
        do_flush   = 1'b0;
        do_start   = 1'b0;
        if (kind)
        begin
            // end of source: flush, report eof, return to reset state
            fa = fl_emit && !err_reg && (mode_reg != M_COMMENT);
            fb = 1'b1;
            res_b.kind   = stok_pkg::TK_EOF;
            res_b.start  = 24'(pos_reg);
            res_b.length = 16'd0;
            res_b.bad    = 8'h00;
            mode_next  = M_IDLE;
            pos_next   = '0;
            begin_next = '0;
            run_next   = '0;
            mask_next  = stok_pkg::ALL_KW;
            err_next   = 1'b0;
        end
        else
        begin
            pos_next = pos_reg + 1'b1;
            if (!err_reg)
            begin
                case (mode_reg)
                    M_IDLE: do_start = 1'b1;
                    M_COMMENT:
                    begin
                        if (char_byte == stok_pkg::CH_LF)
                        begin
                            mode_next = M_IDLE;
                        end
                    end
                    M_SLASH:
                    begin
                        if (char_byte == stok_pkg::CH_SLASH)
                        begin
                            mode_next = M_COMMENT;
                        end
                        else
                        begin
                            do_flush = 1'b1;
                        end
                    end
                    M_AMP, M_PIPE, M_EQ, M_BANG:
                    begin
                        if ((mode_reg == M_AMP && char_byte == stok_pkg::CH_AMP)
                            || (mode_reg == M_PIPE && char_byte == stok_pkg::CH_PIPE)
                            || ((mode_reg == M_EQ || mode_reg == M_BANG)
                                && char_byte == stok_pkg::CH_EQ))
                        begin
                            fa = 1'b1;
                            res_a.length = 16'd2;
                            res_a.bad    = 8'h00;
                            case (mode_reg)
                                M_AMP:   res_a.kind = stok_pkg::TK_AND;
                                M_PIPE:  res_a.kind = stok_pkg::TK_OR;
                                M_EQ:    res_a.kind = stok_pkg::TK_EQEQ;
                                default: res_a.kind = stok_pkg::TK_NE;
                            endcase
                            mode_next = M_IDLE;
                        end
                        else
                        begin
                            do_flush = 1'b1;
                        end
                    end
                    M_NUMBER:
                    begin
                        if (is_digit)
                        begin
                            run_next = run_grow;
                        end
                        else
                        begin
                            do_flush = 1'b1;
                        end
                    end
                    M_IDENT:
                    begin
                        if (is_alnum)
                        begin
                            mask_next = stok_pkg::narrow_mask(mask_reg, run_reg, char_byte);
                            run_next  = run_grow;
                        end
                        else
                        begin
                            do_flush = 1'b1;
                        end
                    end
                    default: do_start = 1'b1;
                endcase
            end
            // end the pending token; a lone & | ! latches an error instead
            if (do_flush)
            begin
                fa        = fl_emit;
                mode_next = M_IDLE;
                if (mode_reg == M_NUMBER || mode_reg == M_IDENT)
                begin
                    run_next = '0;
                end
                if (mode_reg == M_IDENT)
                begin
                    mask_next = stok_pkg::ALL_KW;
                end
                if (fl_err)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    do_start = 1'b1;
                end
            end
            // open a token at this byte
            if (do_start)
            begin
                fb         = st_emit;
                begin_next = pos_reg;
                mode_next  = st_mode;
                if (st_word)
                begin
                    run_next = 16'd1;
                end
                if (st_ident)
                begin
                    mask_next = stok_pkg::narrow_mask(stok_pkg::ALL_KW, 16'd0, char_byte);
                end
                if (st_err)
                begin
                    err_next = 1'b1;
                end
            end
        end
    end

    // Pack the tokens in order into one record
    assign push    = accept && (fa || fb);
    assign rec.r0  = fa ? res_a : res_b;
    assign rec.r1  = res_b;
    assign rec.two = fa && fb;

    // Hold scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            pos_reg   <= '0;
            begin_reg <= '0;
            run_reg   <= '0;
            mask_reg  <= stok_pkg::ALL_KW;
            err_reg   <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            begin_reg <= begin_next;
            run_reg   <= run_next;
            mask_reg  <= mask_next;
            err_reg   <= err_next;
        end
    end

endmodule

/* src/stok_queue.sv */
// Short record queue between the tokenizer front and back ends.
// Depends on stok_pkg.
module stok_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  stok_pkg::record_t  push_rec,
    input  logic               pop,
    output logic               full,
    output logic               head_valid,
    output stok_pkg::record_t  head_rec
);

    localparam int DEPTH    = 4;
    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    stok_pkg::record_t     mem_reg [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic                  do_wr, do_rd;

    assign full       = (count_reg == CNT_BITS'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_rec   = mem_reg[rd_ptr_reg];
    assign do_wr      = push && !full;
    assign do_rd      = pop && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Store records
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

/* src/stok_back.sv */
// Tokenizer back end: unpacks queued records, one token per cycle unless stalled.
// Depends on stok_pkg.
module stok_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  stok_pkg::record_t  head_rec,
    output logic               pop,
    output logic               tok_valid,
    input  logic               tok_stall,
    output logic [4:0]         token_kind,
    output logic [23:0]        token_start,
    output logic [15:0]        token_length,
    output logic [7:0]         bad_char,
    output logic               last
);

    logic              valid_reg;
    logic              half_reg, half_next;
    stok_pkg::result_t res_reg, res_next;
    logic              last_reg, last_next;
    logic              load;

    // Load a new token when the output register is empty or being taken
    assign load      = head_valid && (!valid_reg || !tok_stall);
    assign res_next  = half_reg ? head_rec.r1 : head_rec.r0;
    assign last_next = half_reg || !head_rec.two;
    assign pop       = load && last_next;
    assign half_next = load ? !last_next : half_reg;

    // Hold output valid and the second-half marker
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            half_reg  <= 1'b0;
        end
        else
        begin
            half_reg <= half_next;
            if (!valid_reg || !tok_stall)
            begin
                valid_reg <= head_valid;
            end
        end
    end

    // Hold output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg  <= res_next;
            last_reg <= last_next;
        end
    end

    assign tok_valid    = valid_reg;
    assign token_kind   = res_reg.kind;
    assign token_start  = res_reg.start;
    assign token_length = res_reg.length;
    assign bad_char     = res_reg.bad;
    assign last         = last_reg;

endmodule

/* src/source_tokenizer_top.sv */
// Top level of the source tokenizer: front end, record queue and back end.
// Depends on stok_pkg, stok_front, stok_queue and stok_back.
//
// Usage:
//   Input channel (src_valid / src_stall): one item per accepted edge. kind = 0 carries
//   one source byte in char_byte; kind = 1 marks end of source.
//   Output channel (tok_valid / tok_stall): one token per accepted edge, as token_kind,
//   token_start, token_length and bad_char; last marks the final token of an item.
//   An item yields zero, one or two tokens; end of source always yields an eof token.
// Throughput: one item per cycle while items yield at most one token each and tok_stall
//   is low. The back end sends one token per cycle while not stalled, so a two-token item
//   occupies it longer than a one-token item; the four-record queue between the front and
//   back ends absorbs such bursts, and src_stall rises only when that queue is full.
// Path: an item's first token is written into the queue when the item is accepted, then
//   loaded into the back end's output register, which drives tok_valid and the token.
// Stall: while tok_stall is high the output token holds; the queue keeps filling and the
//   front end keeps taking bytes until the queue is full.
// Reset: rst_n clears the scan state (offset 0, no pending token, no latched error) and
//   empties the queue; no clearing pass is needed. End of source also resets the scan state.
module source_tokenizer_top #(
    parameter int POSITION_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        src_valid,
    output logic        src_stall,
    input  logic        kind,
    input  logic [7:0]  char_byte,
    output logic        tok_valid,
    input  logic        tok_stall,
    output logic [4:0]  token_kind,
    output logic [23:0] token_start,
    output logic [15:0] token_length,
    output logic [7:0]  bad_char,
    output logic        last
);

    logic              accept;
    logic              push, full, pop, head_valid;
    stok_pkg::record_t push_rec, head_rec;

    assign src_stall = full;
    assign accept    = src_valid && !full;

    stok_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .kind      (kind),
        .char_byte (char_byte),
        .push      (push),
        .rec       (push_rec)
    );

    stok_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_rec   (push_rec),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_rec   (head_rec)
    );

    stok_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_rec     (head_rec),
        .pop          (pop),
        .tok_valid    (tok_valid),
        .tok_stall    (tok_stall),
        .token_kind   (token_kind),
        .token_start  (token_start),
        .token_length (token_length),
        .bad_char     (bad_char),
        .last         (last)
    );

endmodule

/* src/stok_checker.sv */
// Port-level checks of the source tokenizer, attached to the top level by bind.
// Depends on stok_pkg and source_tokenizer_top.
module stok_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        tok_valid,
    input logic        tok_stall,
    input logic [4:0]  token_kind,
    input logic [23:0] token_start,
    input logic [15:0] token_length,
    input logic [7:0]  bad_char,
    input logic        last
);

    // Hold a stalled token
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_stall |=> tok_valid)
        else $error("token dropped while stalled");

    // Eof closes its item and has no length
    a_eof_shape: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && token_kind == stok_pkg::TK_EOF |-> last && token_length == 16'd0)
        else $error("malformed eof token");

    // Only error tokens carry a byte
    a_bad_only_err: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && token_kind != stok_pkg::TK_ERROR |-> bad_char == 8'h00)
        else $error("bad_char set on a non-error token");

    // Errors and a lone slash are one byte long
    a_fixed_len: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && (token_kind == stok_pkg::TK_ERROR || token_kind == stok_pkg::TK_SLASH)
        |-> token_length == 16'd1)
        else $error("wrong length on a one-byte token");

    // A taken non-final token is followed by the rest of its item
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !tok_stall && !last |=> tok_valid)
        else $error("second token of an item missing");

endmodule

bind source_tokenizer_top stok_checker u_stok_checker (.*);

/* test/source_tokenizer_top_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for source_tokenizer_top: a directed table and random token
// streams, checked against an in-bench scanner model or, for typed rows, the row itself.
// Depends on stok_pkg and source_tokenizer_top.
module source_tokenizer_top_tb;

    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int DRAIN_LIMIT    = 20_000;
    localparam int QUIET_CYCLES   = 20;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int PHASE_ITEMS    = 125;
    localparam int MAX_PRINTED    = 40;

    // Scanner modes of the bench model
    typedef enum logic [3:0] {
        SM_IDLE, SM_SLASH, SM_COMMENT, SM_AMP, SM_PIPE, SM_EQ, SM_BANG, SM_NUMBER, SM_IDENT
    } scan_state_t;

    typedef struct packed {
        logic [4:0]  kind;
        logic [23:0] start;
        logic [15:0] length;
        logic [7:0]  bad;
        logic        last;
    } token_t;

    // One directed row; typed rows carry their single expected token
    typedef struct packed {
        logic        k;
        logic [7:0]  c;
        logic        typed;
        logic [4:0]  tk;
        logic [23:0] ts;
        logic [15:0] tl;
        logic [7:0]  tb;
    } stim_row_t;

    localparam logic [39:0] KEYWORD_TEXT [6] = '{"print", "if", "while", "else", "input", "let"};

    localparam logic [7:0] OP_BYTES [15] = '{
        stok_pkg::CH_PLUS, stok_pkg::CH_MINUS, stok_pkg::CH_STAR, stok_pkg::CH_SLASH,
        stok_pkg::CH_GT, stok_pkg::CH_LT, stok_pkg::CH_SEMI, stok_pkg::CH_LPAREN,
        stok_pkg::CH_RPAREN, stok_pkg::CH_LBRACE, stok_pkg::CH_RBRACE, stok_pkg::CH_AMP,
        stok_pkg::CH_PIPE, stok_pkg::CH_EQ, stok_pkg::CH_BANG
    };

    localparam int IDLE_PLAN  [4] = '{0, 66, 0, 20};
    localparam int STALL_PLAN [4] = '{0, 0, 66, 20};

    localparam stim_row_t DIRECTED [24] = '{
        // after reset: plus, and-and, lone bang, bytes ignored while latched, eof
        '{1'b0, stok_pkg::CH_PLUS,  1'b1, stok_pkg::TK_PLUS,  24'd0, 16'd1, 8'h00},
        '{1'b0, stok_pkg::CH_AMP,   1'b0, stok_pkg::TK_EOF,   24'd0, 16'd0, 8'h00},
        '{1'b0, stok_pkg::CH_AMP,   1'b1, stok_pkg::TK_AND,   24'd1, 16'd2, 8'h00},
        '{1'b0, stok_pkg::CH_BANG,  1'b0, stok_pkg::TK_EOF,   24'd0, 16'd0, 8'h00},
        '{1'b0, "x",      1'b1, stok_pkg::TK_ERROR, 24'd3, 16'd1, stok_pkg::CH_BANG},
        '{1'b0, 8'hFF,              1'b0, stok_pkg::TK_EOF,   24'd0, 16'd0, 8'h00},
        '{1'b1, 8'hA5,              1'b1, stok_pkg::TK_EOF,   24'd6, 16'd0, 8'h00},
        // lowest and highest bytes as unexpected characters
        '{1'b0, 8'h00,              1'b1, stok_pkg::TK_ERROR, 24'd0, 16'd1, 8'h00},
        '{1'b1, 8'h00,              1'b1, stok_pkg::TK_EOF,   24'd1, 16'd0, 8'h00},
        '{1'b0, 8'hFF,              1'b1, stok_pkg::TK_ERROR, 24'd0, 16'd1, 8'hFF},
        '{1'b1, 8'hFF,              1'b1, stok_pkg::TK_EOF,   24'd1, 16'd0, 8'h00},
        // keyword closed by a comment, end of source inside the comment
        '{1'b0, "i",                1'b0, stok_pkg::TK_EOF,   24'd0, 16'd0, 8'h00},
        '{1'b0, "f",                1'b0, stok_pkg::TK_EOF,   24'd0, 16'd0, 8'h00},
        '{1'b0, stok_pkg::CH_SLASH, 1'b0, stok_pkg::TK_EOF,   24'd0, 16'd0, 8'h00},
        '{1'b0, stok_pkg::CH_SLASH, 1'b0, stok_pkg::TK_EOF,   24'd0, 16'd0, 8'h00},
        '{1'b0, 8'h80,              1'b0, stok_pkg::TK_EOF,   24'd0, 16'd0, 8'h00},
        '{1'b1, 8'h5A,              1'b1, stok_pkg::TK_EOF,   24'd5, 16'd0, 8'h00},
        // number, lone equal, lone pipe pending at end of source
        '{1'b0, "9",                1'b0, stok_pkg::TK_EOF,   24'd0, 16'd0, 8'h00},
        '{1'b0, stok_pkg::CH_EQ,    1'b0, stok_pkg::TK_EOF,   24'd0, 16'd0, 8'h00},
        '{1'b0, stok_pkg::CH_PIPE,  1'b0, stok_pkg::TK_EOF,   24'd0, 16'd0, 8'h00},
        '{1'b1, 8'h3C,              1'b0, stok_pkg::TK_EOF,   24'd0, 16'd0, 8'h00},
        // blank, then a number flushed by end of source
        '{1'b0, stok_pkg::CH_TAB,   1'b0, stok_pkg::TK_EOF,   24'd0, 16'd0, 8'h00},
        '{1'b0, stok_pkg::CH_0,     1'b0, stok_pkg::TK_EOF,   24'd0, 16'd0, 8'h00},
        '{1'b1, 8'hC3,              1'b0, stok_pkg::TK_EOF,   24'd0, 16'd0, 8'h00}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        src_valid;
    logic        src_stall;
    logic        kind;
    logic [7:0]  char_byte;
    logic        tok_valid;
    logic        tok_stall = 1'b0;
    logic [4:0]  token_kind;
    logic [23:0] token_start;
    logic [15:0] token_length;
    logic [7:0]  bad_char;
    logic        last;

    // Bench model of the scanner
    scan_state_t scan_state;
    logic [23:0] cur_offset;
    logic [23:0] tok_origin;
    logic [15:0] tok_len;
    logic [39:0] word_bits;
    logic        err_hold;

    token_t item_tokens[$];
    token_t pending_tokens[$];

    int error_count    = 0;
    int tokens_checked = 0;
    int items_total    = 0;
    int useful_items   = 0;
    int cycle_count    = 0;
    int idle_pct       = 0;
    int stall_pct      = 0;
    int hold_asks      = 0;
    int hold_given     = 0;
    int hold_left      = 0;

    source_tokenizer_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .src_valid    (src_valid),
        .src_stall    (src_stall),
        .kind         (kind),
        .char_byte    (char_byte),
        .tok_valid    (tok_valid),
        .tok_stall    (tok_stall),
        .token_kind   (token_kind),
        .token_start  (token_start),
        .token_length (token_length),
        .bad_char     (bad_char),
        .last         (last)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
        begin
            $display("[%0t] MISMATCH: %s", $time, msg);
        end
    endtask

    function automatic bit is_digit(input logic [7:0] c);
        return c >= stok_pkg::CH_0 && c <= stok_pkg::CH_9;
    endfunction

    function automatic bit is_alpha(input logic [7:0] c);
        return (c >= stok_pkg::CH_LA && c <= stok_pkg::CH_LZ)
            || (c >= stok_pkg::CH_UA && c <= stok_pkg::CH_UZ);
    endfunction

    function automatic void reset_scanner();
        scan_state = SM_IDLE;
        cur_offset = '0;
        tok_origin = '0;
        tok_len    = '0;
        word_bits  = '0;
        err_hold   = 1'b0;
    endfunction

    function automatic void add_token(input logic [4:0] k, input logic [23:0] s,
                                      input logic [15:0] n, input logic [7:0] b);
        token_t t;
        t = {k, s, n, b, 1'b0};
        item_tokens.insert(item_tokens.size(), t);
    endfunction

    // Keyword when the whole word matches one, else identifier
    function automatic logic [4:0] word_token_kind();
        logic [4:0] res;
        res = stok_pkg::TK_IDENT;
        if (tok_len <= 16'd5)
        begin
            for (int k = 0; k < 6; k++)
            begin
                if (word_bits == KEYWORD_TEXT[k])
                begin
                    res = stok_pkg::TK_KW0 + 5'(k);
                end
            end
        end
        return res;
    endfunction

    function automatic void grow_token();
        if (tok_len != stok_pkg::LEN_MAX)
        begin
            tok_len = tok_len + 16'd1;
        end
    endfunction

    // Scan byte c with no token pending
    function automatic void open_token(input logic [7:0] c);
        logic [4:0] op;
        tok_origin = cur_offset;
        case (c)
            stok_pkg::CH_PLUS:   op = stok_pkg::TK_PLUS;
            stok_pkg::CH_MINUS:  op = stok_pkg::TK_MINUS;
            stok_pkg::CH_STAR:   op = stok_pkg::TK_STAR;
            stok_pkg::CH_GT:     op = stok_pkg::TK_GT;
            stok_pkg::CH_LT:     op = stok_pkg::TK_LT;
            stok_pkg::CH_SEMI:   op = stok_pkg::TK_SEMI;
            stok_pkg::CH_LPAREN: op = stok_pkg::TK_LPAREN;
            stok_pkg::CH_RPAREN: op = stok_pkg::TK_RPAREN;
            stok_pkg::CH_LBRACE: op = stok_pkg::TK_LBRACE;
            stok_pkg::CH_RBRACE: op = stok_pkg::TK_RBRACE;
            default:             op = stok_pkg::TK_EOF;
        endcase
        if (op != stok_pkg::TK_EOF)
        begin
            add_token(op, cur_offset, 16'd1, 8'h00);
        end
        else if (c == stok_pkg::CH_SLASH)
        begin
            scan_state = SM_SLASH;
        end
        else if (c == stok_pkg::CH_AMP)
        begin
            scan_state = SM_AMP;
        end
        else if (c == stok_pkg::CH_PIPE)
        begin
            scan_state = SM_PIPE;
        end
        else if (c == stok_pkg::CH_EQ)
        begin
            scan_state = SM_EQ;
        end
        else if (c == stok_pkg::CH_BANG)
        begin
            scan_state = SM_BANG;
        end
        else if (is_digit(c))
        begin
            scan_state = SM_NUMBER;
            tok_len    = 16'd1;
        end
        else if (is_alpha(c))
        begin
            scan_state = SM_IDENT;
            tok_len    = 16'd1;
            word_bits  = {32'd0, c};
        end
        else if (!(c == stok_pkg::CH_SPACE || c == stok_pkg::CH_TAB
                   || c == stok_pkg::CH_CR || c == stok_pkg::CH_LF))
        begin
            add_token(stok_pkg::TK_ERROR, cur_offset, 16'd1, c);
            err_hold = 1'b1;
        end
    endfunction

    // Report the pending token; returns 0 when it turned into an error
    function automatic bit close_pending();
        scan_state_t m;
        bit          go;
        m          = scan_state;
        scan_state = SM_IDLE;
        go         = 1'b1;
        case (m)
            SM_SLASH: add_token(stok_pkg::TK_SLASH, tok_origin, 16'd1, 8'h00);
            SM_EQ:    add_token(stok_pkg::TK_EQUAL, tok_origin, 16'd1, 8'h00);
            SM_NUMBER:
            begin
                add_token(stok_pkg::TK_NUMBER, tok_origin, tok_len, 8'h00);
                tok_len = '0;
            end
            SM_IDENT:
            begin
                add_token(word_token_kind(), tok_origin, tok_len, 8'h00);
                tok_len = '0;
            end
            SM_AMP:
            begin
                add_token(stok_pkg::TK_ERROR, tok_origin, 16'd1, stok_pkg::CH_AMP);
                go = 1'b0;
            end
            SM_PIPE:
            begin
                add_token(stok_pkg::TK_ERROR, tok_origin, 16'd1, stok_pkg::CH_PIPE);
                go = 1'b0;
            end
            SM_BANG:
            begin
                add_token(stok_pkg::TK_ERROR, tok_origin, 16'd1, stok_pkg::CH_BANG);
                go = 1'b0;
            end
            default: ;
        endcase
        if (!go)
        begin
            err_hold = 1'b1;
        end
        return go;
    endfunction

    // Advance the model by one item and collect the tokens it causes in item_tokens
    function automatic void tokenize_item(input logic k, input logic [7:0] c);
        logic [7:0] partner;
        logic [4:0] pair;
        token_t     t;
        item_tokens.delete();
        if (k)
        begin
            if (!err_hold && scan_state != SM_COMMENT)
            begin
                void'(close_pending());
            end
            add_token(stok_pkg::TK_EOF, cur_offset, 16'd0, 8'h00);
            reset_scanner();
        end
        else
        begin
            if (!err_hold)
            begin
                case (scan_state)
                    SM_IDLE: open_token(c);
                    SM_COMMENT:
                    begin
                        if (c == stok_pkg::CH_LF)
                        begin
                            scan_state = SM_IDLE;
                        end
                    end
                    SM_SLASH:
                    begin
                        if (c == stok_pkg::CH_SLASH)
                        begin
                            scan_state = SM_COMMENT;
                        end
                        else if (close_pending())
                        begin
                            open_token(c);
                        end
                    end
                    SM_AMP, SM_PIPE, SM_EQ, SM_BANG:
                    begin
                        partner = (scan_state == SM_AMP) ? stok_pkg::CH_AMP
                                : (scan_state == SM_PIPE) ? stok_pkg::CH_PIPE
                                : stok_pkg::CH_EQ;
                        pair = (scan_state == SM_AMP) ? stok_pkg::TK_AND
                             : (scan_state == SM_PIPE) ? stok_pkg::TK_OR
                             : (scan_state == SM_EQ) ? stok_pkg::TK_EQEQ : stok_pkg::TK_NE;
                        if (c == partner)
                        begin
                            add_token(pair, tok_origin, 16'd2, 8'h00);
                            scan_state = SM_IDLE;
                        end
                        else if (close_pending())
                        begin
                            open_token(c);
                        end
                    end
                    SM_NUMBER:
                    begin
                        if (is_digit(c))
                        begin
                            grow_token();
                        end
                        else if (close_pending())
                        begin
                            open_token(c);
                        end
                    end
                    SM_IDENT:
                    begin
                        if (is_digit(c) || is_alpha(c))
                        begin
                            word_bits = {word_bits[31:0], c};
                            grow_token();
                        end
                        else if (close_pending())
                        begin
                            open_token(c);
                        end
                    end
                    default:
                    begin
                        scan_state = SM_IDLE;
                        open_token(c);
                    end
                endcase
            end
            cur_offset = cur_offset + 24'd1;
        end
        // mark the final token of the item
        if (item_tokens.size() > 0)
        begin
            t      = item_tokens[item_tokens.size() - 1];
            t.last = 1'b1;
            item_tokens[item_tokens.size() - 1] = t;
        end
    endfunction

    // Offer one item, hold it until accepted, then record what it should produce
    task automatic send_item(input logic k, input logic [7:0] c,
                             input bit typed = 1'b0, input token_t want = '0);
        while ($urandom_range(99) < idle_pct)
        begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid <= 1'b1;
        kind      <= k;
        char_byte <= c;
        do
        begin
            @(posedge clk);
        end
        while (src_stall);
        items_total++;
        if (!err_hold || k)
        begin
            useful_items++;
        end
        tokenize_item(k, c);
        if (typed)
        begin
            pending_tokens.insert(pending_tokens.size(), want);
        end
        else
        begin
            while (item_tokens.size() > 0)
            begin
                pending_tokens.insert(pending_tokens.size(), item_tokens.pop_front());
            end
        end
    endtask

    task automatic wait_for_drain();
        int waited;
        waited = 0;
        while (pending_tokens.size() > 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
    endtask

    function automatic logic [7:0] random_alpha();
        int r;
        r = $urandom_range(51);
        return (r < 26) ? stok_pkg::CH_LA + 8'(r) : stok_pkg::CH_UA + 8'(r - 26);
    endfunction

    function automatic logic [7:0] random_alnum();
        return ($urandom_range(3) == 0) ? stok_pkg::CH_0 + 8'($urandom_range(9))
                                        : random_alpha();
    endfunction

    // Send a keyword, leaving off its last drop letters
    task automatic send_word(input logic [39:0] word, input int drop);
        int n;
        n = 0;
        for (int i = 0; i < 5; i++)
        begin
            if (word[i*8 +: 8] != 8'h00)
            begin
                n++;
            end
        end
        for (int i = n - 1; i >= drop; i--)
        begin
            send_item(1'b0, word[i*8 +: 8]);
        end
    endtask

    // One random source: mostly well-formed tokens, some broken operators and noise
    task automatic send_source();
        int         count;
        int         r;
        int         n;
        logic [7:0] b;
        count = $urandom_range(12, 3);
        for (int t = 0; t < count; t++)
        begin
            r = $urandom_range(99);
            if (r < 12)
            begin
                send_word(KEYWORD_TEXT[$urandom_range(5)], 0);
            end
            else if (r < 18)
            begin
                // near miss at random: maybe cut short, maybe run on
                send_word(KEYWORD_TEXT[$urandom_range(5)], $urandom_range(1));
                if ($urandom_range(1))
                begin
                    send_item(1'b0, random_alnum());
                end
            end
            else if (r < 32)
            begin
                send_item(1'b0, random_alpha());
                n = $urandom_range(7);
                repeat (n) send_item(1'b0, random_alnum());
            end
            else if (r < 46)
            begin
                n = $urandom_range(5, 1);
                repeat (n) send_item(1'b0, stok_pkg::CH_0 + 8'($urandom_range(9)));
            end
            else if (r < 80)
            begin
                b = OP_BYTES[$urandom_range(14)];
                send_item(1'b0, b);
                // complete two-byte operators most of the time
                if ((b == stok_pkg::CH_AMP || b == stok_pkg::CH_PIPE
                     || b == stok_pkg::CH_EQ || b == stok_pkg::CH_BANG)
                    && $urandom_range(3) != 0)
                begin
                    send_item(1'b0, (b == stok_pkg::CH_BANG) ? stok_pkg::CH_EQ : b);
                end
            end
            else if (r < 94)
            begin
                send_item(1'b0, stok_pkg::CH_SLASH);
                send_item(1'b0, stok_pkg::CH_SLASH);
                n = $urandom_range(6);
                repeat (n)
                begin
                    b = 8'($urandom_range(255));
                    send_item(1'b0, (b == stok_pkg::CH_LF) ? stok_pkg::CH_SPACE : b);
                end
                send_item(1'b0, stok_pkg::CH_LF);
            end
            else
            begin
                send_item(1'b0, 8'($urandom_range(255)));
            end
            // optional blank between tokens
            if ($urandom_range(3) == 0)
            begin
                case ($urandom_range(3))
                    0: send_item(1'b0, stok_pkg::CH_SPACE);
                    1: send_item(1'b0, stok_pkg::CH_TAB);
                    2: send_item(1'b0, stok_pkg::CH_CR);
                    default: send_item(1'b0, stok_pkg::CH_LF);
                endcase
            end
        end
        send_item(1'b1, 8'($urandom_range(255)));
    endtask

    // Check accepted tokens and drive the output stall
    always @(posedge clk)
    begin : token_sink
        token_t got;
        token_t want;
        if (rst_n && tok_valid && !tok_stall)
        begin
            got = {token_kind, token_start, token_length, bad_char, last};
            tokens_checked++;
            if (pending_tokens.size() == 0)
            begin
                report_mismatch($sformatf("unexpected token kind %0d start %0d length %0d",
                                          got.kind, got.start, got.length));
            end
            else
            begin
                want = pending_tokens.pop_front();
                if (got.kind !== want.kind)
                begin
                    report_mismatch($sformatf("token %0d kind: got %0d expected %0d",
                                              tokens_checked, got.kind, want.kind));
                end
                if (got.start !== want.start)
                begin
                    report_mismatch($sformatf("token %0d start: got %0d expected %0d",
                                              tokens_checked, got.start, want.start));
                end
                if (got.length !== want.length)
                begin
                    report_mismatch($sformatf("token %0d length: got %0d expected %0d",
                                              tokens_checked, got.length, want.length));
                end
                if (got.bad !== want.bad)
                begin
                    report_mismatch($sformatf("token %0d bad_char: got %0h expected %0h",
                                              tokens_checked, got.bad, want.bad));
                end
                if (got.last !== want.last)
                begin
                    report_mismatch($sformatf("token %0d last: got %0b expected %0b",
                                              tokens_checked, got.last, want.last));
                end
            end
        end
        // long hold-off on request, else random stalls
        if (hold_given != hold_asks)
        begin
            hold_left  = HOLDOFF_CYCLES;
            hold_given = hold_asks;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            tok_stall <= 1'b1;
        end
        else
        begin
            tok_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Stop a hung run
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d tokens outstanding",
                 cycle_count, pending_tokens.size());
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : stimulus
        stim_row_t row;
        token_t    want;
        int        first;
        rst_n     <= 1'b0;
        src_valid <= 1'b0;
        kind      <= 1'b0;
        char_byte <= 8'h00;
        reset_scanner();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < 24; i++)
        begin
            row = DIRECTED[i];
            send_item(row.k, row.c, row.typed, {row.tk, row.ts, row.tl, row.tb, 1'b1});
        end
        src_valid <= 1'b0;
        wait_for_drain();

        // random sources under each idle/stall mix; drain between phases
        for (int p = 0; p < 4; p++)
        begin
            idle_pct = IDLE_PLAN[p];
            stall_pct <= STALL_PLAN[p];
            if (p == 0)
            begin
                hold_asks <= hold_asks + 1;
            end
            first = useful_items;
            while (useful_items - first < PHASE_ITEMS)
            begin
                send_source();
            end
            src_valid <= 1'b0;
            wait_for_drain();
        end

        idle_pct = 0;
        repeat (QUIET_CYCLES) @(posedge clk);
        while (pending_tokens.size() > 0)
        begin
            want = pending_tokens.pop_front();
            report_mismatch($sformatf("token kind %0d start %0d never arrived",
                                      want.kind, want.start));
        end

        $display("Checked %0d tokens from %0d items in %0d cycles: directed cases",
                 tokens_checked, items_total, cycle_count);
        $display("and random sources under four idle/stall mixes with a long hold-off.");
        if (error_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/stok_pkg.sv
src/stok_front.sv
src/stok_queue.sv
src/stok_back.sv
src/source_tokenizer_top.sv
src/stok_checker.sv
test/source_tokenizer_top_tb.sv
